// ===== hw/rtl/bcsb_pkg.sv =====
// Shared types and constants of the border-corrected sign binarizer.
// Depends on nothing; the interfaces in bcsb_if and the top level import it; bcsb_ram does not.
`timescale 1ns / 1ps

package bcsb_pkg;

   // Field widths of the request and response words.
   localparam int unsigned KIND_W      = 1;
   localparam int unsigned CHAN_IDX_W  = 9;
   localparam int unsigned THRESH_W    = 16;
   localparam int unsigned SAMPLE_W    = 16;
   localparam int unsigned WORD_W      = 32;

   // Configuration port.
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 11;
   localparam int unsigned HEIGHT_W    = 11;
   localparam int unsigned WIDTH_W     = 11;
   localparam int unsigned GROUPS_W    = 5;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNEL_GROUPS = 2'd2;

   // Request kinds.
   localparam logic [KIND_W-1:0] KIND_LOAD   = 1'b0;
   localparam logic [KIND_W-1:0] KIND_SAMPLE = 1'b1;

   // Channels packed into one response word, and the bit counter width.
   localparam int unsigned GROUP_BITS = 32;
   localparam int unsigned BIT_IDX_W  = 5;

   // Border offsets subtracted from a channel threshold.
   localparam int unsigned OFFSET_W = 9;
   typedef logic [OFFSET_W-1:0] offset_type;

   localparam offset_type EDGE_OFFSET   = 9'd192;
   localparam offset_type CORNER_OFFSET = 9'd320;
   localparam offset_type INNER_OFFSET  = 9'd0;

endpackage

// ===== hw/rtl/bcsb_if.sv =====
// Valid/ready channel interfaces for the request and response words.
// Depends on bcsb_pkg for the field widths.
`timescale 1ns / 1ps

interface bcsb_req_if;
   import bcsb_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [KIND_W-1:0]     kind;
   logic [CHAN_IDX_W-1:0] channel_index;
   logic [THRESH_W-1:0]   threshold_value;
   logic [SAMPLE_W-1:0]   sample;

   modport source (output valid, kind, channel_index, threshold_value, sample,
                   input ready);
   modport sink   (input valid, kind, channel_index, threshold_value, sample,
                   output ready);
endinterface

interface bcsb_rsp_if;
   import bcsb_pkg::*;

   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] packed_bits;
   logic              last_of_pixel;
   logic              last_of_map;

   modport source (output valid, packed_bits, last_of_pixel, last_of_map,
                   input ready);
   modport sink   (input valid, packed_bits, last_of_pixel, last_of_map,
                   output ready);
endinterface

// ===== hw/rtl/bcsb_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
// Stand-alone; used for the threshold table.
`timescale 1ns / 1ps

module bcsb_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/border_corrected_sign_binarizer_core.sv =====
// Top level of the border-corrected sign binarizer.
// Depends on bcsb_pkg, the channel interfaces in bcsb_if and the RAM bcsb_ram.
// The word that a sample completes passes the compare stage and the output register before it is offered.
// Throughput: one request word per cycle; it stalls only behind an untaken output word.
// Reset is synchronous and clears the counters, the configuration registers, the accumulator and all valids;
// the threshold table is not cleared and holds nothing useful until loaded.
`timescale 1ns / 1ps

module border_corrected_sign_binarizer_core #(
   parameter int unsigned MAX_CHANNELS = 512,
   parameter int unsigned MAX_DIM      = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   bcsb_req_if.sink                         req_chan,
   bcsb_rsp_if.source                       rsp_chan,
   input  logic                             csr_write_enable,
   input  logic [bcsb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bcsb_pkg::CSR_DATA_W-1:0]  csr_write_data
);

   import bcsb_pkg::*;

   // Widths that follow from the parameters. The channel group counter keeps
   // at least one bit even when only a single group is possible.
   localparam int unsigned CH_W   = $clog2(MAX_CHANNELS);
   localparam int unsigned CNT_W  = $clog2(MAX_DIM);
   localparam int unsigned GROUPS = MAX_CHANNELS / GROUP_BITS;
   localparam int unsigned GRP_W  = (GROUPS > 1) ? $clog2(GROUPS) : 1;

   // ------------------------------------------------------------------
   // Configuration. Each register is stored as the index of its last row,
   // column or group, already clamped: zero behaves as one and anything
   // above the maximum behaves as the maximum.
   // ------------------------------------------------------------------
   function automatic logic [31:0] last_of_range(logic [31:0] value, int unsigned limit);
      logic [31:0] result;
      if (value == 32'd0) begin
         result = 32'd0;
      end else if (value > 32'(limit)) begin
         result = 32'(limit) - 32'd1;
      end else begin
         result = value - 32'd1;
      end
      return result;
   endfunction

   logic [31:0]      height_last_wide;
   logic [31:0]      width_last_wide;
   logic [31:0]      groups_last_wide;
   logic [CNT_W-1:0] row_last_ff;
   logic [CNT_W-1:0] col_last_ff;
   logic [GRP_W-1:0] grp_last_ff;
   logic             csr_restart;

   assign height_last_wide = last_of_range(32'(csr_write_data[HEIGHT_W-1:0]), MAX_DIM);
   assign width_last_wide  = last_of_range(32'(csr_write_data[WIDTH_W-1:0]), MAX_DIM);
   assign groups_last_wide = last_of_range(32'(csr_write_data[GROUPS_W-1:0]), GROUPS);

   // Any write to a defined register restarts the map.
   assign csr_restart = csr_write_enable &&
                        (csr_index == CSR_IMAGE_HEIGHT || csr_index == CSR_IMAGE_WIDTH ||
                         csr_index == CSR_CHANNEL_GROUPS);

   always_ff @(posedge clock) begin
      if (reset) begin
         row_last_ff <= '0;
         col_last_ff <= '0;
         grp_last_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_IMAGE_HEIGHT:   row_last_ff <= height_last_wide[CNT_W-1:0];
            CSR_IMAGE_WIDTH:    col_last_ff <= width_last_wide[CNT_W-1:0];
            CSR_CHANNEL_GROUPS: grp_last_ff <= groups_last_wide[GRP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Handshake. The only stall is a finished group in the compare stage
   // whose word cannot move into a full output register.
   // ------------------------------------------------------------------
   logic s1_valid_ff;
   logic s1_group_end_ff;
   logic rsp_valid_ff;
   logic stall;
   logic req_fire;
   logic sample_fire;
   logic load_fire;

   assign stall       = s1_valid_ff && s1_group_end_ff && rsp_valid_ff && !rsp_chan.ready;
   assign req_chan.ready = !stall;
   assign req_fire    = req_chan.valid && !stall;
   assign sample_fire = req_fire && (req_chan.kind == KIND_SAMPLE);
   assign load_fire   = req_fire && (req_chan.kind == KIND_LOAD);

   // ------------------------------------------------------------------
   // Stream position. The counters move as each sample is accepted, so the
   // table read for that sample is issued at the same edge.
   // ------------------------------------------------------------------
   logic [BIT_IDX_W-1:0] bit_ff;
   logic [GRP_W-1:0]     grp_ff;
   logic [CNT_W-1:0]     col_ff;
   logic [CNT_W-1:0]     row_ff;
   logic                 group_end;
   logic                 pixel_end;
   logic                 map_end;
   logic                 edge_x;
   logic                 edge_y;
   offset_type           offset;

   assign group_end = (bit_ff == BIT_IDX_W'(GROUP_BITS - 1));
   assign pixel_end = group_end && (grp_ff == grp_last_ff);
   assign map_end   = pixel_end && (col_ff == col_last_ff) && (row_ff == row_last_ff);

   assign edge_x = (col_ff == '0) || (col_ff == col_last_ff);
   assign edge_y = (row_ff == '0) || (row_ff == row_last_ff);

   always_comb begin
      unique case ({edge_x, edge_y})
         2'b11:         offset = CORNER_OFFSET;
         2'b10, 2'b01:  offset = EDGE_OFFSET;
         default:       offset = INNER_OFFSET;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset || csr_restart) begin
         bit_ff <= '0;
         grp_ff <= '0;
         col_ff <= '0;
         row_ff <= '0;
      end else if (sample_fire) begin
         bit_ff <= bit_ff + 1'b1;
         if (pixel_end) begin
            grp_ff <= '0;
            if (col_ff == col_last_ff) begin
               col_ff <= '0;
               row_ff <= (row_ff == row_last_ff) ? '0 : row_ff + 1'b1;
            end else begin
               col_ff <= col_ff + 1'b1;
            end
         end else if (group_end) begin
            grp_ff <= grp_ff + 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------
   // Threshold table. Loads at or above the table depth are dropped. A load
   // and a later sample never share an edge, so a sample always sees every
   // load accepted before it.
   // ------------------------------------------------------------------
   logic [31:0]         load_idx_wide;
   logic [31:0]         read_idx_wide;
   logic                load_in_range;
   logic [THRESH_W-1:0] table_data;

   assign load_idx_wide = 32'(req_chan.channel_index);
   assign load_in_range = load_idx_wide < 32'(MAX_CHANNELS);
   assign read_idx_wide = (32'(grp_ff) << BIT_IDX_W) | 32'(bit_ff);

   bcsb_ram #(
      .WIDTH (THRESH_W),
      .DEPTH (MAX_CHANNELS)
   ) u_threshold_ram (
      .clock   (clock),
      .wr_en   (load_fire && load_in_range),
      .wr_addr (load_idx_wide[CH_W-1:0]),
      .wr_data (req_chan.threshold_value),
      .rd_en   (sample_fire),
      .rd_addr (read_idx_wide[CH_W-1:0]),
      .rd_data (table_data)
   );

   // ------------------------------------------------------------------
   // Compare stage. It holds the sample and what the position decided
   // while the table word arrives from the RAM.
   // ------------------------------------------------------------------
   logic [SAMPLE_W-1:0]  s1_sample_ff;
   offset_type           s1_offset_ff;
   logic [BIT_IDX_W-1:0] s1_bit_ff;
   logic                 s1_pixel_end_ff;
   logic                 s1_map_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!stall) begin
         s1_valid_ff <= sample_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (sample_fire) begin
         s1_sample_ff    <= req_chan.sample;
         s1_offset_ff    <= offset;
         s1_bit_ff       <= bit_ff;
         s1_group_end_ff <= group_end;
         s1_pixel_end_ff <= pixel_end;
         s1_map_end_ff   <= map_end;
      end
   end

   // The threshold is reduced by the border offset with a floor at zero, and
   // twice the sample is compared at full width so that it never wraps.
   logic [THRESH_W-1:0]   reduced;
   logic [SAMPLE_W:0]     doubled;
   logic                  hit;
   logic [WORD_W-1:0]     acc_ff;
   logic [WORD_W-1:0]     acc_merged;
   logic                  s1_advance;

   assign reduced    = (table_data > THRESH_W'(s1_offset_ff)) ?
                       table_data - THRESH_W'(s1_offset_ff) : '0;
   assign doubled    = {s1_sample_ff, 1'b0};
   assign hit        = doubled >= (SAMPLE_W + 1)'(reduced);
   assign acc_merged = hit ? (acc_ff | (WORD_W'(32'h8000_0000) >> s1_bit_ff)) : acc_ff;
   assign s1_advance = s1_valid_ff && !stall;

   always_ff @(posedge clock) begin
      if (reset || csr_restart) begin
         acc_ff <= '0;
      end else if (s1_advance) begin
         acc_ff <= s1_group_end_ff ? '0 : acc_merged;
      end
   end

   // ------------------------------------------------------------------
   // Output register. It parts the compare stage from the consumer, so new
   // samples keep flowing while a finished word waits to be taken, until the
   // next finished group reaches the compare stage.
   logic [WORD_W-1:0] rsp_bits_ff;
   logic              rsp_pixel_ff;
   logic              rsp_map_ff;
   logic              rsp_load;

   assign rsp_load = s1_advance && s1_group_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_bits_ff  <= acc_merged;
         rsp_pixel_ff <= s1_pixel_end_ff;
         rsp_map_ff   <= s1_map_end_ff;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.packed_bits   = rsp_bits_ff;
   assign rsp_chan.last_of_pixel = rsp_pixel_ff;
   assign rsp_chan.last_of_map   = rsp_map_ff;

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (rsp_valid_ff && s1_valid_ff && s1_group_end_ff))
      else $error("request side stalled without a blocked finished group");

   a_map_ends_pixel: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_map_ff) |-> rsp_pixel_ff)
      else $error("end of map flagged on a word that does not end a pixel");

   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      csr_restart |=> (bit_ff == '0 && grp_ff == '0 && col_ff == '0 && row_ff == '0))
      else $error("stream position not cleared by a register write");

   a_position_bounds: assert property (@(posedge clock) disable iff (reset)
      (grp_ff <= grp_last_ff) && (col_ff <= col_last_ff) && (row_ff <= row_last_ff))
      else $error("stream position beyond the configured map");

endmodule
